// ===== hdl/ffh_pkg.sv =====
// ----------------------------------------------------------------------------
// ffh_pkg
// Shared types and constants of the frame fragmenter with datagram header.
// ----------------------------------------------------------------------------
package ffh_pkg;

	// frame length and payload size widths
	localparam int LENGTH_BITS  = 20;
	localparam int PAY_W        = 13;
	localparam int SEQ_W        = 32;
	localparam int WORD_W       = 32;
	localparam int HEADER_BYTES = 25;

	// one output slot per header byte plus one for the payload byte
	localparam int OUT_SLOTS = HEADER_BYTES + 1;
	localparam int SLOT_W    = $clog2(OUT_SLOTS);
	localparam logic [SLOT_W-1:0] PAY_SLOT = SLOT_W'(HEADER_BYTES);
	localparam logic [SLOT_W-1:0] HDR_FIRST_SLOT = '0;

	// divider iteration counter
	localparam int DIV_CNT_W = $clog2(LENGTH_BITS + 1);

	// command queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// configuration register
	localparam logic [PAY_W-1:0] PAY_SIZE_RESET = PAY_W'(1300);
	localparam logic [PAY_W-1:0] PAY_SIZE_MIN   = PAY_W'(1);
	localparam int ADDR_W = 3;
	localparam logic REG_IDX_PAY_SIZE = 1'b0;

	// input item kinds
	typedef enum logic {
		OP_START = 1'b0,
		OP_BYTE  = 1'b1
	} op_t;

	// front state
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DIV  = 2'b10
	} front_state_t;

	// one classified payload byte, ready for the serializer
	typedef struct packed {
		logic [SEQ_W-1:0]       seq;
		logic [LENGTH_BITS-1:0] total;
		logic [LENGTH_BITS-1:0] size;
		logic [LENGTH_BITS-1:0] index;
		logic [PAY_W-1:0]       pay;
		logic [LENGTH_BITS-1:0] offset;
		logic                   last_frag;
		logic                   with_header;
		logic                   dg_end;
		logic [7:0]             data;
	} cmd_t;

endpackage

// ===== hdl/ffh_divider.sv =====
// ----------------------------------------------------------------------------
// ffh_divider
// Restoring divider, one quotient bit per cycle, for the fragment count.
// ----------------------------------------------------------------------------
module ffh_divider import ffh_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [LENGTH_BITS-1:0] dividend,
	input  logic [PAY_W-1:0]       divisor,
	output logic                   done,
	output logic [LENGTH_BITS-1:0] quotient,
	output logic                   rem_nz
);

	logic                   busy_q;
	logic                   done_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [PAY_W:0]         rem_q;
	logic [LENGTH_BITS-1:0] quo_q;
	logic [PAY_W-1:0]       div_q;
	logic [PAY_W:0]         trial;
	logic                   ge;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q[PAY_W-1:0], quo_q[LENGTH_BITS-1]};
	assign ge    = trial >= {1'b0, div_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(LENGTH_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, div_q}) : trial;
			quo_q <= {quo_q[LENGTH_BITS-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
	assign rem_nz   = rem_q != '0;

endmodule

// ===== hdl/ffh_queue.sv =====
// ----------------------------------------------------------------------------
// ffh_queue
// Short command queue between classifier and serializer.
// ----------------------------------------------------------------------------
module ffh_queue import ffh_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  cmd_t  wr_data,
	output logic  wr_ready,
	input  logic  rd_en,
	output cmd_t  rd_data,
	output logic  rd_valid
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_wr;
	logic              do_rd;

	assign wr_ready = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign do_wr    = wr_en && wr_ready;
	assign do_rd    = rd_en && rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (!do_wr && do_rd)
				count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ===== hdl/ffh_front.sv =====
// ----------------------------------------------------------------------------
// ffh_front
// Accepts input items, tracks the open frame and classifies payload bytes.
// ----------------------------------------------------------------------------
module ffh_front import ffh_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [PAY_W-1:0]       pay_size,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   in_op,
	input  logic [LENGTH_BITS-1:0] in_length,
	input  logic [7:0]             in_data,
	output logic                   cmd_valid,
	output cmd_t                   cmd,
	input  logic                   cmd_ready
);

	front_state_t           state_q;
	logic [SEQ_W-1:0]       seq_q;
	logic                   open_q;
	logic [LENGTH_BITS-1:0] total_q;
	logic [LENGTH_BITS-1:0] size_q;
	logic [LENGTH_BITS-1:0] rem_q;
	logic [LENGTH_BITS-1:0] num_q;
	logic [LENGTH_BITS-1:0] off_q;
	logic [PAY_W-1:0]       blf_q;
	logic [PAY_W-1:0]       lp_q;

	logic                   acc;
	logic                   start_acc;
	logic                   byte_acc;
	logic                   div_start;
	logic                   div_done;
	logic [LENGTH_BITS-1:0] div_quo;
	logic                   div_rem_nz;
	logic [LENGTH_BITS-1:0] lp_ext;
	logic [PAY_W-1:0]       pay;
	logic                   last_frag;
	logic                   need_hdr;
	logic [PAY_W-1:0]       nblf;
	logic [LENGTH_BITS-1:0] nrem;

	// handshake
	assign in_ready  = (state_q == ST_IDLE) && cmd_ready;
	assign acc       = in_valid && in_ready;
	assign start_acc = acc && (op_t'(in_op) == OP_START);
	assign byte_acc  = acc && (op_t'(in_op) == OP_BYTE) && open_q;
	assign div_start = start_acc && (in_length != '0);

	// fragment count
	ffh_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_length),
		.divisor  (pay_size),
		.done     (div_done),
		.quotient (div_quo),
		.rem_nz   (div_rem_nz)
	);

	// classify the byte against the open fragment
	assign lp_ext    = LENGTH_BITS'(lp_q);
	assign pay       = (rem_q < lp_ext) ? rem_q[PAY_W-1:0] : lp_q;
	assign last_frag = rem_q <= lp_ext;
	assign need_hdr  = blf_q == '0;
	assign nblf      = (need_hdr ? pay : blf_q) - 1'b1;
	assign nrem      = rem_q - 1'b1;

	assign cmd_valid       = byte_acc;
	assign cmd.seq         = seq_q;
	assign cmd.total       = total_q;
	assign cmd.size        = size_q;
	assign cmd.index       = num_q;
	assign cmd.pay         = pay;
	assign cmd.offset      = off_q;
	assign cmd.last_frag   = last_frag;
	assign cmd.with_header = need_hdr;
	assign cmd.dg_end      = nblf == '0;
	assign cmd.data        = in_data;

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seq_q   <= '0;
			open_q  <= 1'b0;
			total_q <= '0;
			size_q  <= '0;
			rem_q   <= '0;
			num_q   <= '0;
			off_q   <= '0;
			blf_q   <= '0;
			lp_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start_acc) begin
						open_q <= 1'b0;
						blf_q  <= '0;
						if (div_start) begin
							seq_q   <= seq_q + 1'b1;
							size_q  <= in_length;
							rem_q   <= in_length;
							lp_q    <= pay_size;
							num_q   <= '0;
							off_q   <= '0;
							state_q <= ST_DIV;
						end
					end else if (byte_acc) begin
						blf_q <= nblf;
						rem_q <= nrem;
						if (nblf == '0) begin
							num_q <= num_q + 1'b1;
							off_q <= off_q + lp_ext;
							if (nrem == '0) open_q <= 1'b0;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						total_q <= div_quo + LENGTH_BITS'(div_rem_nz);
						open_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/ffh_back.sv =====
// ----------------------------------------------------------------------------
// ffh_back
// Serializes one command: optional 25-byte header, then the payload byte.
// ----------------------------------------------------------------------------
module ffh_back import ffh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        out_end,
	output logic        out_hdr
);

	cmd_t              cur_q;
	logic              cur_valid_q;
	logic [SLOT_W-1:0] slot_q;
	logic              out_acc;
	logic              at_pay;
	logic [WORD_W-1:0] words [6];
	logic [7:0]        slots [OUT_SLOTS];

	assign at_pay  = slot_q == PAY_SLOT;
	assign out_acc = cur_valid_q && out_ready;
	assign cmd_pop = cmd_valid && (!cur_valid_q || (out_acc && at_pay));

	// header words, each sent little-endian
	always_comb begin
		words[0] = cur_q.seq;
		words[1] = WORD_W'(cur_q.total);
		words[2] = WORD_W'(cur_q.size);
		words[3] = WORD_W'(cur_q.index);
		words[4] = WORD_W'(cur_q.pay);
		words[5] = WORD_W'(cur_q.offset);
		for (int k = 0; k < HEADER_BYTES - 1; k++) begin
			slots[k] = words[k / 4][8 * (k % 4) +: 8];
		end
		slots[HEADER_BYTES - 1] = {7'd0, cur_q.last_frag};
		slots[HEADER_BYTES]     = cur_q.data;
	end

	assign out_valid = cur_valid_q;
	assign out_byte  = slots[slot_q];
	assign out_end   = at_pay && cur_q.dg_end;
	assign out_hdr   = !at_pay;

	// slot sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			slot_q      <= PAY_SLOT;
		end else begin
			if (cmd_pop) begin
				cur_valid_q <= 1'b1;
				slot_q      <= cmd.with_header ? HDR_FIRST_SLOT : PAY_SLOT;
			end else if (out_acc) begin
				if (at_pay)
					cur_valid_q <= 1'b0;
				else
					slot_q <= slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) cur_q <= cmd;
	end

endmodule

// ===== hdl/frame_fragmenter_with_header.sv =====
// ----------------------------------------------------------------------------
// frame_fragmenter_with_header
// Splits frames into datagrams, each led by a 25-byte little-endian header.
// ----------------------------------------------------------------------------
// A frame-start item (tuser 0) with a nonzero length opens a frame and stalls
// the input while a one-bit-per-cycle divider works out the fragment count;
// each payload byte (tuser 1) is taken while the four-entry command queue has
// room. The output side sends one byte per cycle while m_axis_tready is high;
// the first byte of each fragment yields 26 bytes (header then payload),
// every other byte one, so the output serializer sets the sustained rate.
// Bytes outside a frame are dropped. A payload size of zero is used as one.
module frame_fragmenter_with_header import ffh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// input items
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [31:0]       s_axis_tdata,  // [19:0] frame_length, [27:20] data_byte
	input  logic              s_axis_tuser,  // [0] op
	// datagram bytes
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,  // [7:0] out_byte
	output logic              m_axis_tlast,  // datagram_end
	output logic              m_axis_tuser   // [0] is_header
);

	logic [PAY_W-1:0] pay_size_q;
	logic [PAY_W-1:0] pay_size_eff;
	logic             q_wr_en;
	logic             q_wr_ready;
	cmd_t             q_wr_data;
	logic             q_rd_en;
	logic             q_rd_valid;
	cmd_t             q_rd_data;

	// register port
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay_size_q <= PAY_SIZE_RESET;
		end else if (psel && penable && pwrite && pready &&
		             paddr[2] == REG_IDX_PAY_SIZE) begin
			pay_size_q <= pwdata[PAY_W-1:0];
		end
	end
	assign prdata = (paddr[2] == REG_IDX_PAY_SIZE) ? 32'(pay_size_q) : '0;

	assign pay_size_eff = (pay_size_q == '0) ? PAY_SIZE_MIN : pay_size_q;

	ffh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pay_size  (pay_size_eff),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_length (s_axis_tdata[LENGTH_BITS-1:0]),
		.in_data   (s_axis_tdata[LENGTH_BITS+7:LENGTH_BITS]),
		.cmd_valid (q_wr_en),
		.cmd       (q_wr_data),
		.cmd_ready (q_wr_ready)
	);

	ffh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_wr_en),
		.wr_data  (q_wr_data),
		.wr_ready (q_wr_ready),
		.rd_en    (q_rd_en),
		.rd_data  (q_rd_data),
		.rd_valid (q_rd_valid)
	);

	ffh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_rd_valid),
		.cmd       (q_rd_data),
		.cmd_pop   (q_rd_en),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_end   (m_axis_tlast),
		.out_hdr   (m_axis_tuser)
	);

endmodule

// ===== hdl/ffh_checker.sv =====
// ----------------------------------------------------------------------------
// ffh_checker
// Port-level checks of the fragmenter, bound to the top level.
// ----------------------------------------------------------------------------
module ffh_checker import ffh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pready,
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,
	input  logic       m_axis_tlast,
	input  logic       m_axis_tuser
);

	logic              out_acc;
	logic [SLOT_W-1:0] hdr_cnt_q;

	assign out_acc = m_axis_tvalid && m_axis_tready;

	// run length of header bytes seen on the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q <= '0;
		end else if (out_acc) begin
			hdr_cnt_q <= m_axis_tuser ? hdr_cnt_q + 1'b1 : '0;
		end
	end

	// stalled output holds its transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
			$stable(m_axis_tuser))
		else $error("output changed while stalled");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	// datagram end falls only on a payload byte
	a_end_on_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser)
		else $error("datagram end on header byte");

	// a payload byte follows either another payload byte or a full header
	a_hdr_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !m_axis_tuser |-> hdr_cnt_q == '0 || hdr_cnt_q == PAY_SLOT)
		else $error("header run length wrong");

	a_hdr_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && m_axis_tuser |-> hdr_cnt_q < PAY_SLOT)
		else $error("header longer than expected");

endmodule

bind frame_fragmenter_with_header ffh_checker u_ffh_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pready        (pready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
